### rtl/fm_index_backward_step_assert.svh
// assertion macros for the fm index backward step block
// used by the top level only
`ifndef FM_INDEX_BACKWARD_STEP_ASSERT_SVH
`define FM_INDEX_BACKWARD_STEP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define FMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fmi_pkg.sv
// shared types and codes for the fm index backward step block
// no dependencies
package fmi_pkg;
  localparam int unsigned FieldW = 17;

  typedef enum logic [1:0] {
    REQ_TEXT  = 2'd0,
    REQ_CKPT  = 2'd1,
    REQ_TOTAL = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FieldW-1:0] position;
    logic [FieldW-1:0] range_end;
    logic [9:0]        bucket_index;
    logic [7:0]        symbol;
    logic [FieldW-1:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic [FieldW-1:0] next_start;
    logic [FieldW-1:0] next_end;
    logic [FieldW-1:0] occurrences;
    logic              status;
  } out_word_t;
endpackage

### rtl/fmi_if.sv
// valid/ready channel interface carrying one word
// depends on fmi_pkg for the word types
interface fmi_in_if;
  logic               valid;
  logic               ready;
  fmi_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fmi_out_if;
  logic               valid;
  logic               ready;
  fmi_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fmi_ram.sv
// generic single port ram with registered read
// no dependencies
module fmi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/fm_index_backward_step.sv
// fm index backward step: each query makes two rank lookups, each a checkpoint
// read and a partial bucket scan of the text memory at one byte a cycle
// one item at a time; the next word is taken while a result waits in the
// output register, and a finished query holds until that register is free
// synchronous active-low reset clears control state and the running total
// memories are not cleared, unwritten entries read as undefined
module fm_index_backward_step #(
  parameter int unsigned MAX_TEXT     = 65536,
  parameter int unsigned BUCKET_SHIFT = 6
) (
  input  logic clk,
  input  logic rst_n,
  fmi_in_if.sink    in_ch,
  fmi_out_if.source out_ch
);
  import fmi_pkg::*;
  `include "fm_index_backward_step_assert.svh"

  localparam int unsigned TextAw   = $clog2(MAX_TEXT);
  localparam int unsigned NBuckets = MAX_TEXT >> BUCKET_SHIFT;
  localparam int unsigned CkDepth  = NBuckets * 256;
  localparam int unsigned CkAw     = $clog2(CkDepth);
  localparam int unsigned BkW      = TextAw - BUCKET_SHIFT;
  localparam int unsigned ScanN    = 1 << BUCKET_SHIFT;
  localparam int unsigned CntW     = BUCKET_SHIFT + 1;
  localparam logic [FieldW-1:0] FieldMax = '1;
  localparam logic [FieldW:0]   MaxTextV = (FieldW+1)'(MAX_TEXT);

  typedef enum logic [2:0] {
    S_IDLE, S_CKRD, S_CKWAIT, S_SCAN, S_NEXT, S_SUM, S_OUT
  } state_t;

  state_t            state_r;
  in_word_t          item_r;
  logic [FieldW-1:0] total_r;
  logic              second_r;
  logic [FieldW-1:0] rank_r, rlo_r;
  logic [FieldW:0]   pos_r;       // rank target point
  logic [CntW-1:0]   scan_r;      // bytes issued in current bucket scan
  logic              rd_pend_r;   // a text read is in flight
  out_word_t         out_r;
  logic              out_v_r;

  // memory ports
  logic              txt_we, ck_we, ss_we;
  logic [TextAw-1:0] txt_addr;
  logic [7:0]        txt_rd;
  logic [CkAw-1:0]   ck_addr;
  logic [FieldW-1:0] ck_rd, ss_rd;
  logic [7:0]        ss_addr;
  logic [FieldW-1:0] ss_wdata;

  // symbol zero starts a new set of totals at row zero
  assign ss_wdata = (item_r.symbol == 8'd0) ? '0 : total_r;

  fmi_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text (
    .clk(clk), .we(txt_we), .addr(txt_addr), .wdata(item_r.load_value[7:0]), .rdata(txt_rd));
  fmi_ram #(.WIDTH(FieldW), .DEPTH(CkDepth)) u_ckpt (
    .clk(clk), .we(ck_we), .addr(ck_addr), .wdata(item_r.load_value), .rdata(ck_rd));
  fmi_ram #(.WIDTH(FieldW), .DEPTH(256)) u_sstart (
    .clk(clk), .we(ss_we), .addr(ss_addr), .wdata(ss_wdata), .rdata(ss_rd));

  // bucket of rank target
  logic [FieldW:0] bucket;
  logic [FieldW:0] base;      // first byte of bucket
  logic [FieldW:0] cur;       // byte issued this cycle
  logic [FieldW:0] sum_tot;
  logic [FieldW:0] text_len;
  logic            bad;
  logic [FieldW-1:0] occ, ns;
  logic            out_free;  // result register can take a new word

  assign bucket   = pos_r >> BUCKET_SHIFT;
  assign base     = bucket << BUCKET_SHIFT;
  assign cur      = base + (FieldW+1)'(scan_r);
  assign sum_tot  = {1'b0, total_r} + {1'b0, item_r.load_value};
  assign text_len = ({1'b0, total_r} > MaxTextV) ? MaxTextV : {1'b0, total_r};
  assign bad      = (item_r.position > item_r.range_end)
                    || ({1'b0, item_r.range_end} > text_len);
  assign occ      = rank_r - rlo_r;
  assign ns       = ss_rd + rlo_r;
  assign out_free = !out_v_r || out_ch.ready;

  // memory control
  always_comb begin
    txt_we   = 1'b0;
    ck_we    = 1'b0;
    ss_we    = 1'b0;
    txt_addr = TextAw'(item_r.position);
    ck_addr  = CkAw'({item_r.bucket_index, item_r.symbol});
    ss_addr  = item_r.symbol;
    case (state_r)
      S_CKRD: begin
        case (item_r.req_type)
          REQ_TEXT:  txt_we = ({1'b0, item_r.position} < MaxTextV);
          REQ_CKPT:  ck_we  = (32'(item_r.bucket_index) < NBuckets);
          REQ_TOTAL: ss_we  = 1'b1;
          default: begin
            // checkpoint of the bucket before the target point
            ck_addr = CkAw'({bucket[BkW-1:0] - BkW'(1), item_r.symbol});
          end
        endcase
      end
      S_SCAN: txt_addr = cur[TextAw-1:0];
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  logic scan_issue;
  assign scan_issue = (state_r == S_SCAN) && (scan_r < CntW'(ScanN)) && (cur < pos_r)
                      && (cur < MaxTextV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      out_v_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_v_r <= 1'b0;
      rd_pend_r <= scan_issue;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r   <= in_ch.data;
            pos_r    <= {1'b0, in_ch.data.position};
            second_r <= 1'b0;
            state_r  <= S_CKRD;
          end
        end
        S_CKRD: begin
          if (item_r.req_type == REQ_TOTAL) begin
            if (item_r.symbol == 8'd0) begin
              // totals restart at symbol zero
              total_r <= item_r.load_value;
            end else begin
              total_r <= sum_tot[FieldW] ? FieldMax : sum_tot[FieldW-1:0];
            end
            state_r <= S_IDLE;
          end else if (item_r.req_type != REQ_QUERY) begin
            state_r <= S_IDLE;
          end else if (bad) begin
            // wait here while an earlier result is still unclaimed
            if (out_free) begin
              out_r   <= '{next_start: '0, next_end: '0, occurrences: '0, status: 1'b1};
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_CKWAIT;
          end
        end
        S_CKWAIT: begin
          rank_r  <= (bucket != '0) ? ck_rd : '0;
          scan_r  <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_issue) scan_r <= scan_r + CntW'(1);
          if (rd_pend_r && txt_rd == item_r.symbol) rank_r <= rank_r + FieldW'(1);
          if (!scan_issue && !rd_pend_r) state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (!second_r) begin
            rlo_r    <= rank_r;
            second_r <= 1'b1;
            pos_r    <= {1'b0, item_r.range_end};
            state_r  <= S_CKRD;
          end else begin
            state_r <= S_SUM;   // symbol start read settles
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_r   <= '{next_start: ns, next_end: ns + occ, occurrences: occ, status: 1'b0};
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FMI_ASSERT_IMP(a_ready_idle, in_ch.ready, state_r == S_IDLE, "ready outside idle")
  `FMI_ASSERT_NEXT(a_out_hold, out_v_r && !out_ch.ready, out_v_r && $stable(out_r), "result lost")
  `FMI_ASSERT_IMP(a_no_write_query, item_r.req_type == REQ_QUERY && state_r != S_IDLE,
                  !txt_we && !ck_we && !ss_we, "query wrote memory")
endmodule

### sim/tb_fm_index_backward_step.sv
// testbench for the fm index backward step block: loads text, checkpoints and
// symbol totals, then checks backward-search queries against a local predictor
// depends on fmi_pkg, fmi_if and the fm_index_backward_step top level
`timescale 1ns / 1ps

module tb_fm_index_backward_step;
  import fmi_pkg::*;

  localparam int unsigned MaxText     = 65536;
  localparam int unsigned BucketShift = 6;
  localparam int unsigned NumBuckets  = MaxText >> BucketShift;
  localparam int unsigned Alphabet    = 256;
  localparam logic [16:0] FieldMax    = 17'h1FFFF;
  localparam int unsigned ItemGoal    = 1900;
  localparam int unsigned QuietFrom   = 1650;  // no idling past this word count
  localparam int unsigned StallLimit  = 5000;  // cycles with nothing accepted
  localparam int unsigned LongHold    = 600;   // receiver hold-off for back pressure

  logic clk;
  logic rst_n;

  fmi_in_if  in_ch ();
  fmi_out_if out_ch ();

  fm_index_backward_step dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the block's stores, plus which entries hold data
  logic [7:0]  text_mem [MaxText];
  bit          text_wr [MaxText];
  logic [16:0] ckpt_mem [NumBuckets*Alphabet];
  bit          ckpt_wr [NumBuckets*Alphabet];
  logic [16:0] sym_start [Alphabet];
  bit          sym_wr [Alphabet];
  logic [16:0] run_total;

  out_word_t pending_steps[$];
  int        errors;
  int        words_sent;
  bit        quiet;
  bit        hold_req;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } step_row_t;

  step_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_word_t mk(req_t rq, int pos, int rend, int bkt, int sym, int val);
    in_word_t w;
    w.req_type     = rq;
    w.position     = pos[16:0];
    w.range_end    = rend[16:0];
    w.bucket_index = bkt[9:0];
    w.symbol       = sym[7:0];
    w.load_value   = val[16:0];
    return w;
  endfunction

  function automatic out_word_t res(int ns, int ne, int occ, bit st);
    out_word_t r;
    r.next_start  = ns[16:0];
    r.next_end    = ne[16:0];
    r.occurrences = occ[16:0];
    r.status      = st;
    return r;
  endfunction

  function automatic logic [16:0] text_len();
    return (run_total > MaxText) ? 17'(MaxText) : run_total;
  endfunction

  // rank: checkpoint of the bucket before p plus a scan of the partial bucket
  function automatic logic [16:0] rank_at(int p, int s);
    int          b;
    logic [16:0] r;
    b = p >> BucketShift;
    r = '0;
    if (b > 0 && b - 1 < NumBuckets) r = ckpt_mem[(b-1)*Alphabet + s];
    for (int i = b << BucketShift; i < p && i < MaxText; i++)
      if (text_mem[i] == s[7:0]) r = r + 17'd1;
    return r;
  endfunction

  // true when a query reads only entries that were written
  function automatic bit reads_written(int p, int s);
    int b;
    b = p >> BucketShift;
    if (b > 0 && b - 1 < NumBuckets && !ckpt_wr[(b-1)*Alphabet + s]) return 0;
    for (int i = b << BucketShift; i < p && i < MaxText; i++)
      if (!text_wr[i]) return 0;
    return 1;
  endfunction

  function automatic bit is_bad_range(in_word_t w);
    return (w.position > w.range_end) || (w.range_end > text_len());
  endfunction

  function automatic bit query_allowed(in_word_t w);
    if (is_bad_range(w)) return 1;
    return sym_wr[w.symbol] && reads_written(w.position, w.symbol)
           && reads_written(w.range_end, w.symbol);
  endfunction

  // state update for one accepted word; queries return the expected step
  function automatic bit predict_step(in_word_t w, output out_word_t r);
    logic [16:0] lo, hi, occ, ns;
    logic [17:0] sum;
    r = '0;
    case (req_t'(w.req_type))
      REQ_TEXT: begin
        if (w.position < MaxText) begin
          text_mem[w.position] = w.load_value[7:0];
          text_wr[w.position]  = 1'b1;
        end
        return 0;
      end
      REQ_CKPT: begin
        if (w.bucket_index < NumBuckets) begin
          ckpt_mem[w.bucket_index*Alphabet + w.symbol] = w.load_value;
          ckpt_wr[w.bucket_index*Alphabet + w.symbol]  = 1'b1;
        end
        return 0;
      end
      REQ_TOTAL: begin
        if (w.symbol == 8'd0) run_total = '0;
        sym_start[w.symbol] = run_total;
        sym_wr[w.symbol]    = 1'b1;
        sum = {1'b0, run_total} + {1'b0, w.load_value};
        run_total = (sum > FieldMax) ? FieldMax : sum[16:0];
        return 0;
      end
      default: begin
        if (is_bad_range(w)) begin
          r = res(0, 0, 0, 1'b1);
        end else begin
          lo  = rank_at(w.position, w.symbol);
          hi  = rank_at(w.range_end, w.symbol);
          occ = hi - lo;
          ns  = sym_start[w.symbol] + lo;
          r.next_start  = ns;
          r.next_end    = ns + occ;
          r.occurrences = occ;
          r.status      = 1'b0;
        end
        return 1;
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // drive one word, wait for the handshake, then book the expectation
  task automatic send_word(in_word_t w, bit typed = 0, out_word_t want = '0);
    out_word_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (predict_step(w, r)) pending_steps.push_back(typed ? want : r);
  endtask

  // receiver: random ready bursts, one long hold-off once a result waits
  initial begin
    bit held;
    held = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held && out_ch.valid) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_steps.size() == 0) begin
        flag_mismatch("unexpected result word", 1, 0);
      end else begin
        want = pending_steps.pop_front();
        if (out_ch.data.next_start !== want.next_start)
          flag_mismatch("next_start", out_ch.data.next_start, want.next_start);
        if (out_ch.data.next_end !== want.next_end)
          flag_mismatch("next_end", out_ch.data.next_end, want.next_end);
        if (out_ch.data.occurrences !== want.occurrences)
          flag_mismatch("occurrences", out_ch.data.occurrences, want.occurrences);
        if (out_ch.data.status !== want.status)
          flag_mismatch("status", out_ch.data.status, want.status);
      end
    end
  end

  // watchdog: too long with no word moving on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("fm_index_backward_step verification failed");
        $finish;
      end
    end
  end

  // random query: mostly legal ranges over the loaded text, some bad ranges
  task automatic make_query(int syms[$], int tlen, output in_word_t w);
    int s, e, p, tl;
    tl = text_len();
    for (int k = 0; k < 20; k++) begin
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                      : syms[$urandom_range(0, syms.size()-1)];
      if ($urandom_range(0, 6) == 0) begin
        if (tl < MaxText && $urandom_range(0, 1)) begin
          e = $urandom_range(tl + 1, 131071);
          p = $urandom_range(0, 131071);
        end else begin
          p = $urandom_range(1, 131071);
          e = $urandom_range(0, p - 1);
        end
      end else begin
        e = $urandom_range(0, (tl < tlen + 8) ? tl : tlen + 8);
        p = ($urandom_range(0, 7) == 0) ? e : $urandom_range(0, e);
      end
      w = mk(REQ_QUERY, p, e, $urandom_range(0, 1023), s, $urandom_range(0, 131071));
      if (query_allowed(w)) return;
    end
    w = mk(REQ_QUERY, 1, 0, 0, 0, 0);
  endtask

  task automatic run_phase();
    int syms[$];
    int tlen, mode, sum, v, cnt, lim;
    in_word_t w;
    tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 900) : $urandom_range(1, 200);
    // keep the total word count near the goal
    if (tlen > int'(ItemGoal) - words_sent) tlen = int'(ItemGoal) - words_sent;
    repeat ($urandom_range(1, 4)) syms.push_back($urandom_range(0, 255));
    syms.sort();
    // text bytes drawn mostly from the queried symbols so counts are nonzero
    for (int i = 0; i < tlen; i++) begin
      v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                      : syms[$urandom_range(0, syms.size()-1)];
      send_word(mk(REQ_TEXT, i, $urandom_range(0, 131071), $urandom_range(0, 1023),
                   $urandom_range(0, 255), ($urandom_range(0, 511) << 8) | v));
    end
    // checkpoints: true counts, sometimes arbitrary values
    for (int b = 0; b <= (tlen >> BucketShift); b++)
      foreach (syms[j]) begin
        cnt = 0;
        lim = ((b + 1) << BucketShift < tlen) ? (b + 1) << BucketShift : tlen;
        for (int i = 0; i < lim; i++) if (text_mem[i] == syms[j]) cnt++;
        if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, 131071);
        send_word(mk(REQ_CKPT, $urandom_range(0, 131071), $urandom_range(0, 131071),
                     b, syms[j], cnt));
      end
    // totals in symbol order; the last one sets the text length
    mode = $urandom_range(0, 2);
    sum = $urandom_range(0, tlen / 2);
    send_word(mk(REQ_TOTAL, $urandom_range(0, 131071), 0, 0, 0, sum));
    foreach (syms[j]) if (syms[j] != 0) begin
      if (j == syms.size() - 1)
        v = (mode == 2) ? 131071 : ((tlen > sum) ? tlen - sum : 0)
            + ((mode == 1) ? $urandom_range(0, 100) : 0);
      else v = $urandom_range(0, tlen / 4);
      send_word(mk(REQ_TOTAL, $urandom_range(0, 131071), 0, $urandom_range(0, 1023),
                   syms[j], v));
      sum += v;
    end
    if (syms[syms.size()-1] == 0 && sum < tlen)
      send_word(mk(REQ_TOTAL, 0, 0, 0, 255, tlen - sum));
    repeat ($urandom_range(20, 60)) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary loads, tracked by the predictor
        w = mk(req_t'($urandom_range(0, 2)), $urandom_range(0, 131071),
               $urandom_range(0, 131071), $urandom_range(0, 1023),
               $urandom_range(1, 255), $urandom_range(0, 131071));
      end else make_query(syms, tlen, w);
      send_word(w);
    end
  endtask

  initial begin
    errors       = 0;
    words_sent   = 0;
    quiet        = 0;
    hold_req     = 0;
    run_total    = '0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;

    // directed rows: results typed in only where they are plain to see
    directed_rows.push_back('{mk(REQ_QUERY, 1, 0, 0, 0, 0), 1, res(0, 0, 0, 1)});
    directed_rows.push_back('{mk(REQ_TOTAL, 0, 0, 0, 0, 3), 0, '0});
    directed_rows.push_back('{mk(REQ_TOTAL, 0, 0, 0, 7, 2), 0, '0});
    directed_rows.push_back('{mk(REQ_TEXT, 0, 0, 0, 0, 7), 0, '0});
    directed_rows.push_back('{mk(REQ_TEXT, 1, 0, 0, 0, 0), 0, '0});
    directed_rows.push_back('{mk(REQ_TEXT, 2, 0, 0, 0, 7), 0, '0});
    directed_rows.push_back('{mk(REQ_TEXT, 3, 0, 0, 0, 131071), 0, '0});
    directed_rows.push_back('{mk(REQ_TEXT, 4, 0, 0, 0, 7), 0, '0});
    directed_rows.push_back('{mk(REQ_QUERY, 0, 5, 0, 7, 0), 1, res(3, 6, 3, 0)});
    directed_rows.push_back('{mk(REQ_QUERY, 2, 5, 0, 7, 0), 1, res(4, 6, 2, 0)});
    directed_rows.push_back('{mk(REQ_QUERY, 0, 6, 0, 7, 0), 1, res(0, 0, 0, 1)});
    directed_rows.push_back('{mk(REQ_QUERY, 3, 4, 0, 0, 0), 0, '0});
    // out-of-range text load is dropped; last bucket gets a full-scale count
    directed_rows.push_back('{mk(REQ_TEXT, 65536, 0, 0, 0, 9), 0, '0});
    directed_rows.push_back('{mk(REQ_CKPT, 0, 0, 1023, 7, 131071), 0, '0});
    // saturating total lifts the text length to its cap
    directed_rows.push_back('{mk(REQ_TOTAL, 0, 0, 0, 255, 131071), 0, '0});
    directed_rows.push_back('{mk(REQ_QUERY, 65536, 65536, 0, 7, 0), 1, res(2, 2, 0, 0)});
    directed_rows.push_back('{mk(REQ_QUERY, 65536, 0, 0, 7, 0), 1, res(0, 0, 0, 1)});
    directed_rows.push_back('{mk(REQ_QUERY, 0, 4, 0, 0, 0), 0, '0});
    // symbol zero total clears the running total
    directed_rows.push_back('{mk(REQ_TOTAL, 0, 0, 0, 0, 0), 0, '0});
    directed_rows.push_back('{mk(REQ_QUERY, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0)});
    directed_rows.push_back('{mk(REQ_QUERY, 0, 1, 0, 0, 0), 1, res(0, 0, 0, 1)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; words_sent < ItemGoal; ph++) begin
      if (ph == 1) hold_req = 1;
      if (words_sent >= QuietFrom) quiet = 1;
      run_phase();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);

    if (errors == 0) $display("fm_index_backward_step verification clean");
    else $display("fm_index_backward_step verification failed");
    $finish;
  end
endmodule
